// ===== hw/rtl/tpp_pkg.sv =====
// Shared types and constants for the transfer packet parser.
// Used by every module of the block; depends on nothing else.
package tpp_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DATA_CODE  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_START_CODE = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_END_CODE   = 2'd2;

    // Reset values of the packet codes
    localparam logic [7:0] RST_DATA_CODE  = 8'd1;
    localparam logic [7:0] RST_START_CODE = 8'd2;
    localparam logic [7:0] RST_END_CODE   = 8'd3;

    // Bytes of a data packet header before the payload
    localparam int HEADER_BYTES = 4;
    // Header positions
    localparam int POS_INDEX    = 1;
    localparam int POS_LEN_HIGH = 2;
    localparam int POS_LEN_LOW  = 3;

    typedef enum logic [1:0] {
        PK_OTHER = 2'd0,
        PK_DATA  = 2'd1,
        PK_START = 2'd2,
        PK_END   = 2'd3
    } t_packet_kind;

    typedef enum logic [1:0] {
        PH_TYPE   = 2'd0,
        PH_LENGTH = 2'd1,
        PH_VALUE  = 2'd2
    } t_field_phase;

    typedef enum logic [1:0] {
        BK_NONE    = 2'd0,
        BK_PAYLOAD = 2'd1,
        BK_VALUE   = 2'd2
    } t_byte_kind;

    typedef enum logic [1:0] {
        VD_DATA  = 2'd0,
        VD_START = 2'd1,
        VD_END   = 2'd2,
        VD_BAD   = 2'd3
    } t_verdict;

    typedef struct packed {
        logic [7:0] data_code;
        logic [7:0] start_code;
        logic [7:0] end_code;
    } t_codes;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        t_byte_kind byte_kind;
        logic [7:0] out_byte;
        logic [7:0] field_type;
        logic       packet_done;
        t_verdict   verdict;
        logic [7:0] seq_index;
        logic       seq_mismatch;
    } t_result;

endpackage

// ===== hw/rtl/tpp_cfg_regs.sv =====
// Packet code registers of the transfer packet parser.
// Depends on tpp_pkg.
module tpp_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [tpp_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [7:0]                       i_cfg_data,
    output logic                             o_cfg_ready,
    output tpp_pkg::t_codes                  o_codes
);

    tpp_pkg::t_codes r_codes;
    tpp_pkg::t_codes n_codes;

    // Always ready: a write is registered and takes effect in the cycle after it is taken
    assign o_cfg_ready = 1'b1;
    assign o_codes     = r_codes;

    // Decode the register index; unknown indexes are dropped
    always_comb begin
        n_codes = r_codes;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                tpp_pkg::CFG_DATA_CODE:  n_codes.data_code  = i_cfg_data;
                tpp_pkg::CFG_START_CODE: n_codes.start_code = i_cfg_data;
                tpp_pkg::CFG_END_CODE:   n_codes.end_code   = i_cfg_data;
                default:                 n_codes = r_codes;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_codes.data_code  <= tpp_pkg::RST_DATA_CODE;
            r_codes.start_code <= tpp_pkg::RST_START_CODE;
            r_codes.end_code   <= tpp_pkg::RST_END_CODE;
        end else begin
            r_codes <= n_codes;
        end
    end

endmodule

// ===== hw/rtl/tpp_parse_core.sv =====
// Per-byte parse state and result logic of the transfer packet parser.
// Depends on tpp_pkg.
module tpp_parse_core #(
    parameter int COUNT_BITS = 17
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  tpp_pkg::t_in_item i_item,
    input  tpp_pkg::t_codes   i_codes,
    output tpp_pkg::t_result  o_result
);

    // Width that holds both the byte count and the declared length
    localparam int CMP_BITS = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;
    localparam logic [COUNT_BITS-1:0] POS_MAX = {COUNT_BITS{1'b1}};

    logic [COUNT_BITS-1:0]   r_pos, n_pos;
    tpp_pkg::t_packet_kind   r_kind, n_kind;
    logic [15:0]             r_dlen, n_dlen;
    logic [7:0]              r_cidx, n_cidx;
    logic [7:0]              r_exp, n_exp;
    tpp_pkg::t_field_phase   r_phase, n_phase;
    logic [7:0]              r_rem, n_rem;
    logic [7:0]              r_type, n_type;
    logic                    r_nonempty, n_nonempty;
    logic [2:0]              r_match, n_match;

    logic                    sat;
    logic                    tlv_ok;
    logic                    data_ok;
    logic [CMP_BITS-1:0]     payload_count;
    logic [7:0]              b;

    assign b   = i_item.rx_byte;
    assign sat = (r_pos == POS_MAX);
    // Bytes after the header, valid when the count reaches a full header
    assign payload_count = CMP_BITS'(r_pos) + CMP_BITS'(1)
                         - CMP_BITS'(tpp_pkg::HEADER_BYTES);

    // Work out the result and next state for the byte at the input
    always_comb begin
        n_pos      = r_pos;
        n_kind     = r_kind;
        n_dlen     = r_dlen;
        n_cidx     = r_cidx;
        n_exp      = r_exp;
        n_phase    = r_phase;
        n_rem      = r_rem;
        n_type     = r_type;
        n_nonempty = r_nonempty;
        n_match    = r_match;
        o_result   = '0;
        tlv_ok     = 1'b0;
        data_ok    = 1'b0;

        if (r_pos == '0) begin
            // Code byte: take the code matches, data first
            n_match = {b == i_codes.end_code, b == i_codes.start_code,
                       b == i_codes.data_code};
            if (n_match[0])      n_kind = tpp_pkg::PK_DATA;
            else if (n_match[1]) n_kind = tpp_pkg::PK_START;
            else if (n_match[2]) n_kind = tpp_pkg::PK_END;
            else                 n_kind = tpp_pkg::PK_OTHER;
        end else begin
            // Capture the data header
            if (r_pos == COUNT_BITS'(tpp_pkg::POS_INDEX))    n_cidx = b;
            if (r_pos == COUNT_BITS'(tpp_pkg::POS_LEN_HIGH)) n_dlen[15:8] = b;
            if (r_pos == COUNT_BITS'(tpp_pkg::POS_LEN_LOW))  n_dlen[7:0] = b;

            // Pass out payload bytes of a data packet
            if (r_kind == tpp_pkg::PK_DATA
                && r_pos >= COUNT_BITS'(tpp_pkg::HEADER_BYTES)) begin
                o_result.byte_kind = tpp_pkg::BK_PAYLOAD;
                o_result.out_byte  = b;
            end

            // Walk the type, length, value chain
            case (r_phase)
                tpp_pkg::PH_TYPE: begin
                    n_type  = b;
                    n_phase = tpp_pkg::PH_LENGTH;
                end
                tpp_pkg::PH_LENGTH: begin
                    n_rem      = b;
                    n_nonempty = (b != 8'd0);
                    n_phase    = (b != 8'd0) ? tpp_pkg::PH_VALUE : tpp_pkg::PH_TYPE;
                end
                default: begin
                    if (r_kind == tpp_pkg::PK_START || r_kind == tpp_pkg::PK_END) begin
                        o_result.byte_kind  = tpp_pkg::BK_VALUE;
                        o_result.out_byte   = b;
                        o_result.field_type = r_type;
                    end
                    n_rem = r_rem - 8'd1;
                    if (n_rem == 8'd0) n_phase = tpp_pkg::PH_TYPE;
                end
            endcase
        end

        if (i_item.last_byte) begin
            // Judge the packet on its final byte
            tlv_ok  = (n_phase == tpp_pkg::PH_TYPE) && ((r_pos == '0) || n_nonempty);
            data_ok = !sat && n_match[0]
                    && (r_pos >= COUNT_BITS'(tpp_pkg::HEADER_BYTES))
                    && (CMP_BITS'(n_dlen) == payload_count);
            o_result.packet_done = 1'b1;
            if (data_ok) begin
                o_result.verdict      = tpp_pkg::VD_DATA;
                o_result.seq_index    = n_cidx;
                o_result.seq_mismatch = (n_cidx != r_exp);
                n_exp = r_exp + 8'd1;
            end else if (!sat && n_match[1] && tlv_ok) begin
                o_result.verdict = tpp_pkg::VD_START;
                n_exp = 8'd0;
            end else if (!sat && n_match[2] && tlv_ok) begin
                o_result.verdict = tpp_pkg::VD_END;
                n_exp = 8'd0;
            end else begin
                o_result.verdict = tpp_pkg::VD_BAD;
            end
            // Clear the per-packet state
            n_pos      = '0;
            n_kind     = tpp_pkg::PK_OTHER;
            n_dlen     = 16'd0;
            n_cidx     = 8'd0;
            n_phase    = tpp_pkg::PH_TYPE;
            n_rem      = 8'd0;
            n_type     = 8'd0;
            n_nonempty = 1'b0;
            n_match    = 3'd0;
        end else begin
            // Advance the byte count, holding at its ceiling
            n_pos = sat ? r_pos : r_pos + COUNT_BITS'(1);
        end
    end

    // Hold state between transactions
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_kind     <= tpp_pkg::PK_OTHER;
            r_dlen     <= 16'd0;
            r_cidx     <= 8'd0;
            r_exp      <= 8'd0;
            r_phase    <= tpp_pkg::PH_TYPE;
            r_rem      <= 8'd0;
            r_type     <= 8'd0;
            r_nonempty <= 1'b0;
            r_match    <= 3'd0;
        end else if (i_accept) begin
            r_pos      <= n_pos;
            r_kind     <= n_kind;
            r_dlen     <= n_dlen;
            r_cidx     <= n_cidx;
            r_exp      <= n_exp;
            r_phase    <= n_phase;
            r_rem      <= n_rem;
            r_type     <= n_type;
            r_nonempty <= n_nonempty;
            r_match    <= n_match;
        end
    end

endmodule

// ===== hw/rtl/tpp_out_skid.sv =====
// Result register with a skid stage for the transfer packet parser.
// Depends on tpp_pkg.
module tpp_out_skid (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  tpp_pkg::t_result i_data,
    output logic             o_full,
    output logic             o_valid,
    output tpp_pkg::t_result o_data,
    input  logic             i_stall
);

    logic             r_out_valid, n_out_valid;
    tpp_pkg::t_result r_out, n_out;
    logic             r_skid_valid, n_skid_valid;
    tpp_pkg::t_result r_skid, n_skid;

    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // Refill the output register when it empties, park a result otherwise
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (!r_out_valid || !i_stall) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out        = i_data;
                n_out_valid  = i_load;
            end
        end else if (i_load) begin
            n_skid       = i_data;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

endmodule

// ===== hw/rtl/transfer_packet_parser.sv =====
// Top level of the transfer packet parser: code registers, parse core, output stage.
// Depends on tpp_pkg, tpp_cfg_regs, tpp_parse_core and tpp_out_skid.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+-------------------------------
//   input    | i_in_valid / o_in_stall | i_in_data  (rx_byte, last_byte)
//   result   | o_out_valid/i_out_stall | o_out_data (one per byte)
//   config   | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// One byte per cycle while the input is not stalled; each result is registered in the output stage.
// The rate is set by the parse core, a single pass from state to result register.
// Synchronous active-low reset clears the parse state and the sequence index, and
// restores the default codes.
// A stalled result is held and one more result parks in the skid stage; the input
// stalls only while that stage is full.
module transfer_packet_parser #(
    parameter int COUNT_BITS = 17
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  tpp_pkg::t_in_item                i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output tpp_pkg::t_result                 o_out_data,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [tpp_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [7:0]                       i_cfg_data
);

    tpp_pkg::t_codes  codes;
    tpp_pkg::t_result result;
    logic             accept;
    logic             skid_full;

    assign o_in_stall = skid_full;
    assign accept     = i_in_valid && !skid_full;

    tpp_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_codes     (codes)
    );

    tpp_parse_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_in_data),
        .i_codes  (codes),
        .o_result (result)
    );

    tpp_out_skid u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_data  (result),
        .o_full  (skid_full),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .i_stall (i_out_stall)
    );

endmodule

// ===== hw/rtl/tpp_checker.sv =====
// Port-level checks for the transfer packet parser, bound to the top level.
// Depends on tpp_pkg and transfer_packet_parser.
module tpp_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input tpp_pkg::t_result o_out_data
);

    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // No result straight after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Mid-packet results carry no verdict
    a_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.packet_done |->
            o_out_data.verdict == tpp_pkg::VD_DATA && o_out_data.seq_index == 8'd0)
        else $error("verdict outside a final byte");

    // Mismatch only on a data verdict
    a_mismatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.seq_mismatch |->
            o_out_data.packet_done && o_out_data.verdict == tpp_pkg::VD_DATA)
        else $error("sequence mismatch without data verdict");

    // Field type only on value bytes
    a_ftype: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.byte_kind != tpp_pkg::BK_VALUE |->
            o_out_data.field_type == 8'd0)
        else $error("field type outside a value byte");

endmodule

bind transfer_packet_parser tpp_checker u_tpp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// ===== tb/tb_transfer_packet_parser.sv =====
// Self-checking testbench for the transfer packet parser top level.
// Depends on tpp_pkg and transfer_packet_parser; predicts each result with a behavioural model.
`timescale 1ns / 100ps

module tb_transfer_packet_parser;

    localparam int CNT_BITS = 17;
    localparam logic [CNT_BITS-1:0] POS_MAX = '1;
    localparam int RUN_LIMIT = 1_000_000;
    localparam int REPORT_MAX = 10;
    localparam int DRAIN_CYCLES = 8;
    // Index with no register behind it
    localparam logic [tpp_pkg::CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             in_valid = 1'b0;
    logic                             in_stall;
    tpp_pkg::t_in_item                in_data = '0;
    logic                             out_valid;
    logic                             out_stall = 1'b0;
    tpp_pkg::t_result                 out_data;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [tpp_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [7:0]                       cfg_data = '0;

    // Parser state as predicted
    tpp_pkg::t_codes       codes_now;
    logic [CNT_BITS-1:0]   byte_pos;
    tpp_pkg::t_packet_kind pkt_kind;
    logic [15:0]           decl_len;
    logic [7:0]            cap_idx;
    logic [7:0]            next_idx;
    tpp_pkg::t_field_phase phase;
    logic [7:0]            value_left;
    logic [7:0]            cur_type;
    logic                  final_nonempty;
    logic [2:0]            code_hits;

    tpp_pkg::t_result pending_results[$];
    tpp_pkg::t_result want;
    logic [7:0]       pkt[$];
    int               fail_count = 0;
    int               bytes_sent = 0;
    int               burst_left = 0;
    int               gap_max = 0;
    int               stall_max = 0;
    int               stall_left = 0;
    int               free_left = 0;

    transfer_packet_parser #(
        .COUNT_BITS(CNT_BITS)
    ) u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    // Clear the per-packet part of the predicted state
    function automatic void clear_packet_state();
        byte_pos = '0;
        pkt_kind = tpp_pkg::PK_OTHER;
        decl_len = '0;
        cap_idx = '0;
        phase = tpp_pkg::PH_TYPE;
        value_left = '0;
        cur_type = '0;
        final_nonempty = 1'b0;
        code_hits = '0;
    endfunction

    // Work out the result of one byte and advance the predicted state
    function automatic tpp_pkg::t_result parse_byte(tpp_pkg::t_in_item it);
        tpp_pkg::t_result    r;
        logic [CNT_BITS-1:0] p;
        logic [7:0]          b;
        int                  count;
        logic                sat;
        logic                tlv_ok;
        r = '0;
        p = byte_pos;
        b = it.rx_byte;
        if (p == 0) begin
            code_hits = {b == codes_now.end_code, b == codes_now.start_code,
                         b == codes_now.data_code};
            pkt_kind = code_hits[0] ? tpp_pkg::PK_DATA : code_hits[1] ? tpp_pkg::PK_START :
                       code_hits[2] ? tpp_pkg::PK_END : tpp_pkg::PK_OTHER;
        end else begin
            if (p == tpp_pkg::POS_INDEX) cap_idx = b;
            else if (p == tpp_pkg::POS_LEN_HIGH) decl_len[15:8] = b;
            else if (p == tpp_pkg::POS_LEN_LOW) decl_len[7:0] = b;

            if (pkt_kind == tpp_pkg::PK_DATA && p >= tpp_pkg::HEADER_BYTES) begin
                r.byte_kind = tpp_pkg::BK_PAYLOAD;
                r.out_byte = b;
            end

            // Walk the type, length, value chain whatever the packet kind
            case (phase)
                tpp_pkg::PH_TYPE: begin
                    cur_type = b;
                    phase = tpp_pkg::PH_LENGTH;
                end
                tpp_pkg::PH_LENGTH: begin
                    value_left = b;
                    final_nonempty = (b != 0);
                    phase = (b != 0) ? tpp_pkg::PH_VALUE : tpp_pkg::PH_TYPE;
                end
                default: begin
                    if (pkt_kind == tpp_pkg::PK_START || pkt_kind == tpp_pkg::PK_END) begin
                        r.byte_kind = tpp_pkg::BK_VALUE;
                        r.out_byte = b;
                        r.field_type = cur_type;
                    end
                    value_left = value_left - 8'd1;
                    if (value_left == 0) phase = tpp_pkg::PH_TYPE;
                end
            endcase
        end

        if (it.last_byte) begin
            sat = (p == POS_MAX);
            count = int'(p) + 1;
            tlv_ok = (phase == tpp_pkg::PH_TYPE) && (count == 1 || final_nonempty);
            r.packet_done = 1'b1;
            if (!sat && code_hits[0] && count >= tpp_pkg::HEADER_BYTES + 1 &&
                int'(decl_len) == count - tpp_pkg::HEADER_BYTES) begin
                r.verdict = tpp_pkg::VD_DATA;
                r.seq_index = cap_idx;
                r.seq_mismatch = (cap_idx != next_idx);
                next_idx = next_idx + 8'd1;
            end else if (!sat && code_hits[1] && tlv_ok) begin
                r.verdict = tpp_pkg::VD_START;
                next_idx = '0;
            end else if (!sat && code_hits[2] && tlv_ok) begin
                r.verdict = tpp_pkg::VD_END;
                next_idx = '0;
            end else begin
                r.verdict = tpp_pkg::VD_BAD;
            end
            clear_packet_state();
        end else begin
            byte_pos = (p < POS_MAX) ? p + 1'b1 : POS_MAX;
        end
        return r;
    endfunction

    // Send one byte in bursts with random gaps; predict it once accepted
    task automatic send_byte(input logic [7:0] b, input logic last);
        tpp_pkg::t_in_item item;
        int                gap;
        item = {b, last};
        @(negedge clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data <= item;
        do @(posedge clk); while (in_stall);
        pending_results.push_back(parse_byte(item));
        bytes_sent++;
    endtask

    task automatic send_packet();
        for (int i = 0; i < pkt.size(); i++) send_byte(pkt[i], i == pkt.size() - 1);
    endtask

    // Hold input idle until every expected result has arrived
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    // Write the three codes and poke the unused index; call only while idle
    task automatic set_codes(input logic [7:0] d, input logic [7:0] s, input logic [7:0] e);
        logic [tpp_pkg::CFG_IDX_BITS-1:0] idx[4];
        logic [7:0]                       val[4];
        idx = '{tpp_pkg::CFG_DATA_CODE, tpp_pkg::CFG_START_CODE, tpp_pkg::CFG_END_CODE,
                CFG_UNUSED};
        val = '{d, s, e, 8'($urandom)};
        for (int i = 0; i < 4; i++) begin
            @(negedge clk);
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= val[i];
            do @(posedge clk); while (!cfg_ready);
            case (idx[i])
                tpp_pkg::CFG_DATA_CODE:  codes_now.data_code = val[i];
                tpp_pkg::CFG_START_CODE: codes_now.start_code = val[i];
                tpp_pkg::CFG_END_CODE:   codes_now.end_code = val[i];
                default: ;
            endcase
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Reset codes: valid packets of each kind, broken data and start packets, index mismatch
    task automatic test_reset_codes();
        gap_max = 0;
        stall_max = 0;
        pkt = {8'h01, 8'h00, 8'h00, 8'h01, 8'hAA};
        send_packet();
        pkt = {8'h01, 8'h07, 8'h00, 8'h01, 8'hFF};
        send_packet();
        pkt = {8'h02};
        send_packet();
        pkt = {8'h03, 8'hFF, 8'h01, 8'h00};
        send_packet();
        pkt = {8'h02, 8'h10, 8'h00};
        send_packet();
        pkt = {8'h00};
        send_packet();
        pkt = {8'h01, 8'h00, 8'h00, 8'h00};
        send_packet();
        drain();
    endtask

    // Equal codes: data takes priority over start, start over end
    task automatic test_equal_codes();
        set_codes(8'hFF, 8'hFF, 8'hFF);
        pkt = {8'hFF, next_idx, 8'h00, 8'h01, 8'h55};
        send_packet();
        pkt = {8'hFF, 8'h10, 8'h01, 8'hAA};
        send_packet();
        drain();
        set_codes(8'h00, 8'h80, 8'h80);
        pkt = {8'h80, 8'h07, 8'h01, 8'h33};
        send_packet();
        pkt = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        send_packet();
        drain();
    endtask

    // Mostly well-formed packets with random content, the rest broken or noise
    task automatic random_phase(input int n_bytes);
        int         start;
        int         sel;
        int         plen;
        int         nf;
        int         v;
        logic [15:0] dl;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes) begin
            sel = $urandom_range(0, 9);
            if (sel <= 2 || sel == 6) begin
                plen = ($urandom_range(0, 24) == 0) ? $urandom_range(256, 300) :
                       $urandom_range(0, 10);
                dl = 16'(plen);
                if (sel == 6) dl = $urandom_range(0, 1) ? dl + 16'd1 : dl - 16'd1;
                pkt = {codes_now.data_code,
                       ($urandom_range(0, 4) == 0) ? 8'($urandom) : next_idx,
                       dl[15:8], dl[7:0]};
                repeat (plen) pkt.push_back(8'($urandom));
                // Cut some broken ones short inside the header
                if (sel == 6 && $urandom_range(0, 1)) begin
                    v = $urandom_range(1, tpp_pkg::HEADER_BYTES);
                    while (pkt.size() > v) void'(pkt.pop_back());
                end
            end else if (sel <= 5 || sel == 7) begin
                pkt = {$urandom_range(0, 1) ? codes_now.start_code : codes_now.end_code};
                nf = (sel == 7) ? $urandom_range(1, 3) : $urandom_range(0, 3);
                for (int i = 0; i < nf; i++) begin
                    v = ($urandom_range(0, 15) == 0) ? $urandom_range(200, 255) :
                        $urandom_range(0, 5);
                    if (i == nf - 1 && v == 0) v = 1;
                    pkt.push_back(8'($urandom));
                    pkt.push_back(8'(v));
                    repeat (v) pkt.push_back(8'($urandom));
                end
                // Break the chain: empty final field or truncated value
                if (sel == 7) begin
                    if ($urandom_range(0, 1)) begin
                        pkt.push_back(8'($urandom));
                        pkt.push_back(8'h00);
                    end else begin
                        void'(pkt.pop_back());
                    end
                end
            end else begin
                pkt = {(sel == 8) ? 8'($urandom) : codes_now.data_code};
                repeat ($urandom_range(0, 9)) pkt.push_back(8'($urandom));
            end
            send_packet();
        end
        drain();
    endtask

    task automatic test_random();
        set_codes(8'h00, 8'hFF, 8'h80);
        gap_max = 4;
        stall_max = 2;
        random_phase(150);
        set_codes(8'hFF, 8'h00, 8'h7F);
        gap_max = 0;
        stall_max = 6;
        random_phase(150);
        set_codes(8'($urandom), 8'($urandom), 8'($urandom));
        gap_max = 6;
        stall_max = 0;
        random_phase(150);
        codes_now.start_code = 8'($urandom);
        set_codes(8'($urandom), codes_now.start_code, codes_now.start_code);
        gap_max = 2;
        stall_max = 3;
        random_phase(150);
        set_codes(tpp_pkg::RST_DATA_CODE, tpp_pkg::RST_START_CODE, tpp_pkg::RST_END_CODE);
        gap_max = 0;
        stall_max = 0;
        random_phase(150);
    endtask

    // Receiver stall pattern: free runs and stall runs of random length
    always @(negedge clk) begin
        if (stall_left > 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end else if (free_left > 0) begin
            free_left--;
            out_stall <= 1'b0;
        end else begin
            free_left = $urandom_range(0, 10);
            stall_left = (stall_max == 0) ? 0 : $urandom_range(1, stall_max);
            out_stall <= 1'b0;
        end
    end

    // Compare each result transaction with the oldest prediction
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("%0t: result with no prediction waiting", $realtime);
            end else begin
                want = pending_results.pop_front();
                if (out_data !== want) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX) begin
                        $display("%0t: mismatch kind %0d/%0d byte %h/%h type %h/%h",
                                 $realtime, want.byte_kind, out_data.byte_kind,
                                 want.out_byte, out_data.out_byte,
                                 want.field_type, out_data.field_type);
                        $display("    done %0d/%0d verdict %0d/%0d seq %h/%h mism %0d/%0d",
                                 want.packet_done, out_data.packet_done,
                                 want.verdict, out_data.verdict,
                                 want.seq_index, out_data.seq_index,
                                 want.seq_mismatch, out_data.seq_mismatch);
                    end
                end
            end
        end
    end

    // Abort a hung run
    initial begin
        repeat (RUN_LIMIT) @(posedge clk);
        $display("tb_transfer_packet_parser failed");
        $finish;
    end

    initial begin
        codes_now = '{data_code: tpp_pkg::RST_DATA_CODE, start_code: tpp_pkg::RST_START_CODE,
                      end_code: tpp_pkg::RST_END_CODE};
        next_idx = '0;
        clear_packet_state();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_codes();
        test_equal_codes();
        test_random();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("tb_transfer_packet_parser passed");
        end else begin
            $display("tb_transfer_packet_parser failed");
        end
        $finish;
    end

endmodule
